FILE: sv/tcb_pkg.sv
// Shared types and constants for the clipped text cell buffer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package tcb_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 64;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_PAINT = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_COLS      = 2'd0;
   localparam logic [1:0] REG_ROWS      = 2'd1;
   localparam logic [1:0] REG_SHIFT_COL = 2'd2;
   localparam logic [1:0] REG_SHIFT_ROW = 2'd3;

   localparam logic [7:0] RST_COLS  = 8'd128;
   localparam logic [6:0] RST_ROWS  = 7'd64;
   localparam logic [7:0] BLANK_GLYPH = 8'h20;
   localparam logic [4:0] WHITE_IDX   = 5'd31;
   localparam logic [4:0] BLACK_IDX   = 5'd0;

   typedef struct packed {
      logic [7:0]         cols;
      logic [6:0]         rows;
      logic signed [15:0] shift_col;
      logic signed [15:0] shift_row;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic wr_glyph;
      logic wr_paint;
   } mem_ctl_type;

endpackage

FILE: sv/tcb_csr.sv
// Configuration register file of the clipped text cell buffer.
// Depends on tcb_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module tcb_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tcb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output tcb_pkg::cfg_type           cfg
);
   import tcb_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols      <= RST_COLS;
         cfg_ff.rows      <= RST_ROWS;
         cfg_ff.shift_col <= 16'sd0;
         cfg_ff.shift_row <= 16'sd0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_COLS:      cfg_ff.cols      <= csr_pwdata[7:0];
            REG_ROWS:      cfg_ff.rows      <= csr_pwdata[6:0];
            REG_SHIFT_COL: cfg_ff.shift_col <= csr_pwdata[15:0];
            REG_SHIFT_ROW: cfg_ff.shift_row <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COLS:      csr_prdata = {24'd0, cfg_ff.cols};
         REG_ROWS:      csr_prdata = {25'd0, cfg_ff.rows};
         REG_SHIFT_COL: csr_prdata = {16'd0, cfg_ff.shift_col};
         REG_SHIFT_ROW: csr_prdata = {16'd0, cfg_ff.shift_row};
         default:       csr_prdata = 32'd0;
      endcase
   end

endmodule

FILE: sv/tcb_clip.sv
// Translation and clipping of one cell access; yields hit and cell address.
// Depends on tcb_pkg for cfg_type.
`timescale 1ns / 1ps

module tcb_clip #(
   parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
   parameter int AW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
   input  tcb_pkg::cfg_type   cfg,
   input  logic signed [15:0] col,
   input  logic signed [15:0] row,
   output logic               hit,
   output logic [AW-1:0]      addr
);
   import tcb_pkg::*;

   localparam logic [8:0] MaxColsW = 9'(MAX_COLS);
   localparam logic [8:0] MaxRowsW = 9'(MAX_ROWS);

   logic signed [16:0] x;
   logic signed [16:0] y;
   logic [8:0]         w;
   logic [8:0]         h;
   logic               in_x;
   logic               in_y;
   logic [31:0]        addr_full;

   assign x = {col[15], col} + {cfg.shift_col[15], cfg.shift_col};
   assign y = {row[15], row} + {cfg.shift_row[15], cfg.shift_row};
   assign w = ({1'b0, cfg.cols} > MaxColsW) ? MaxColsW : {1'b0, cfg.cols};
   assign h = ({2'b0, cfg.rows} > MaxRowsW) ? MaxRowsW : {2'b0, cfg.rows};

   assign in_x = !x[16] && (x[15:0] < {7'd0, w});
   assign in_y = !y[16] && (y[15:0] < {7'd0, h});
   assign hit  = in_x & in_y;

   assign addr_full = 32'(y[15:0]) * 32'(MAX_COLS) + 32'(x[15:0]);
   assign addr      = addr_full[AW-1:0];

endmodule

FILE: sv/tcb_store.sv
// Cell store: glyph and color memories with a clearing pass after reset.
// Depends on tcb_pkg for mem_ctl_type and blank cell constants.
`timescale 1ns / 1ps

module tcb_store #(
   parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
   parameter int AW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcb_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]        addr,
   input  logic [7:0]           glyph,
   input  logic [4:0]           fore_colour,
   input  logic [4:0]           back_colour,
   output logic [7:0]           rd_glyph,
   output logic [4:0]           rd_fore,
   output logic [4:0]           rd_back,
   output logic                 busy
);
   import tcb_pkg::*;

   localparam int Cells = MAX_COLS * MAX_ROWS;
   localparam logic [AW-1:0] LastAddr = AW'(Cells - 1);

   logic [7:0]    glyph_mem [Cells];
   logic [9:0]    paint_mem [Cells];
   logic [7:0]    rd_glyph_ff;
   logic [9:0]    rd_paint_ff;
   logic          busy_ff;
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == LastAddr) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         glyph_mem[clr_ff] <= BLANK_GLYPH;
         paint_mem[clr_ff] <= {BLACK_IDX, WHITE_IDX};
      end else begin
         if (ctl.wr_glyph) begin
            glyph_mem[addr] <= glyph;
         end
         if (ctl.wr_paint) begin
            paint_mem[addr] <= {back_colour, fore_colour};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_glyph_ff <= glyph_mem[addr];
         rd_paint_ff <= paint_mem[addr];
      end
   end

   assign rd_glyph = rd_glyph_ff;
   assign rd_fore  = rd_paint_ff[4:0];
   assign rd_back  = rd_paint_ff[9:5];
   assign busy     = busy_ff;

endmodule

FILE: sv/text_cell_buffer_clipped.sv
// Top level of the clipped text cell buffer.
// Depends on tcb_pkg, tcb_csr, tcb_clip and tcb_store.
//
// Request beats on req_* carry one cell access: tuser is the opcode (draw,
// set colors, read), tdata the column, row, glyph and color indices. The
// offsets in the CSR block are added to column and row and the cell is
// clipped against the configured width and height. Every request gives
// one response beat on rsp_*: tuser is hit, tdata the cell read back
// (zero unless a read hit).
// A request passes the request stage, then the response stage. One request
// is taken every cycle unless the response stalls; this is set by the
// single access per cycle on each cell memory, with read data registered
// in the memory stage. After reset a clearing pass writes a blank cell
// (space, white on black) to each of the MAX_COLS*MAX_ROWS entries, one
// entry per cycle; req_tready stays low until it ends, while CSR writes
// are taken as usual. When rsp_tready is low the response beat
// holds, the request stage holds, and req_tready drops once both are full.
// Write CSRs only while the block is idle.
`timescale 1ns / 1ps

module text_cell_buffer_clipped #(
   parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [55:0]                req_tdata,  // col, row, glyph, fore_colour, back_colour, pad
   input  logic [1:0]                 req_tuser,  // opcode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // read_glyph, read_fore, read_back, pad
   output logic                       rsp_tuser,  // hit
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tcb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import tcb_pkg::*;

   localparam int AW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1;

   cfg_type            cfg;
   mem_ctl_type        ctl;
   logic               busy;
   logic               advance;
   logic               req_beat;
   logic               hit;
   logic [AW-1:0]      addr;
   logic [7:0]         rd_glyph;
   logic [4:0]         rd_fore;
   logic [4:0]         rd_back;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [1:0]         s1_op_ff;
   logic signed [15:0] s1_col_ff;
   logic signed [15:0] s1_row_ff;
   logic [7:0]         s1_glyph_ff;
   logic [4:0]         s1_fore_ff;
   logic [4:0]         s1_back_ff;
   logic               s2_valid_ff;
   logic               s2_hit_ff;
   logic               s2_read_ff;

   tcb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcb_clip #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .AW       (AW)
   ) u_clip (
      .cfg  (cfg),
      .col  (s1_col_ff),
      .row  (s1_row_ff),
      .hit  (hit),
      .addr (addr)
   );

   tcb_store #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .AW       (AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .addr        (addr),
      .glyph       (s1_glyph_ff),
      .fore_colour (s1_fore_ff),
      .back_colour (s1_back_ff),
      .rd_glyph    (rd_glyph),
      .rd_fore     (rd_fore),
      .rd_back     (rd_back),
      .busy        (busy)
   );

   assign advance    = !s2_valid_ff || rsp_tready;
   assign req_tready = !busy && (!s1_valid_ff || advance);
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!s1_valid_ff || advance) begin
         s1_valid_in = req_beat;
      end
   end

   always_comb begin
      ctl.rd_en    = s1_valid_ff && advance && hit && (s1_op_ff == OP_READ);
      ctl.wr_glyph = s1_valid_ff && advance && hit && (s1_op_ff == OP_DRAW);
      ctl.wr_paint = s1_valid_ff && advance && hit &&
                     (s1_op_ff == OP_DRAW || s1_op_ff == OP_PAINT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_col_ff   <= req_tdata[15:0];
         s1_row_ff   <= req_tdata[31:16];
         s1_glyph_ff <= req_tdata[39:32];
         s1_fore_ff  <= req_tdata[44:40];
         s1_back_ff  <= req_tdata[49:45];
         s1_op_ff    <= req_tuser;
      end
      if (advance) begin
         s2_hit_ff  <= hit;
         s2_read_ff <= hit && (s1_op_ff == OP_READ);
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tuser  = s2_hit_ff;
   assign rsp_tdata  = s2_read_ff ? {6'd0, rd_back, rd_fore, rd_glyph} : 24'd0;

   a_no_beat_while_clearing : assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("request taken during clearing pass");

   a_no_write_on_stall : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_tready) |-> !(ctl.wr_glyph || ctl.wr_paint || ctl.rd_en))
      else $error("cell memory accessed while response stalled");

   a_s1_held_on_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_op_ff)))
      else $error("stalled request stage lost its item");

endmodule
